### design/gtig_pkg.sv
// Shared constants, types and step codes of the grid triangle index generator.
`default_nettype none

package gtig_pkg;

  localparam int MAX_RESOLUTION = 1024;

  // Field widths fixed by the interface
  localparam int CFG_RES_W = 11;
  localparam int IDX_W     = 20;
  localparam int CFG_IDX_W = 1;

  // Derived internal widths
  localparam int COORD_W   = $clog2(MAX_RESOLUTION);
  localparam int RES_W     = COORD_W + 1;
  localparam int DIM_W     = RES_W + 2;
  localparam int NUM_BANDS = 4;
  localparam int BAND_W    = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RING_MODE  = CFG_IDX_W'(1);

  localparam logic [CFG_RES_W-1:0] RES_RESET = CFG_RES_W'(64);

  // Geometry sequencer steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_DIMS      = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_MUL       = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_SUM       = STEP_W'(1 + NUM_BANDS);
  localparam logic [STEP_W-1:0] STEP_RESETTLE  = STEP_W'(2 * NUM_BANDS);
  localparam logic [STEP_W-1:0] STEP_IDLE      = STEP_W'(2 * NUM_BANDS + 1);

  typedef struct packed {
    logic [COORD_W-1:0] wd;
    logic [COORD_W-1:0] qc;
    logic [COORD_W-1:0] qr;
    logic               ok;
  } band_geom_t;

  typedef struct packed {
    band_geom_t [NUM_BANDS-1:0]            band;
    logic       [NUM_BANDS-1:0][IDX_W-1:0] base;
    logic                                  ring;
  } geom_t;

  typedef struct packed {
    logic [BAND_W-1:0]  band;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [IDX_W-1:0]   rsi;
    logic [IDX_W-1:0]   base;
    logic               sh;
    logic               fin;
  } walk_t;

  // Walk state out of reset: all counters clear, nothing left until a restart
  localparam walk_t WALK_RESET = '{band: '0, col: '0, row: '0, rsi: '0, base: '0,
                                   sh: 1'b0, fin: 1'b1};

endpackage

`default_nettype wire

### design/gtig_geom.sv
// Configuration registers and band geometry sequencer.
`default_nettype none

module gtig_geom (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [gtig_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gtig_pkg::CFG_RES_W-1:0]    cfg_data,
  output gtig_pkg::geom_t                   geom,
  output logic                              busy,
  output logic                              resettle
);

  logic [gtig_pkg::CFG_RES_W-1:0] resolution;
  logic                           ring_mode;
  logic [gtig_pkg::STEP_W-1:0]    step;

  logic [gtig_pkg::COORD_W-1:0] wd [gtig_pkg::NUM_BANDS];
  logic [gtig_pkg::COORD_W-1:0] hd [gtig_pkg::NUM_BANDS];
  logic [gtig_pkg::IDX_W-1:0]   vc [gtig_pkg::NUM_BANDS];
  logic [gtig_pkg::IDX_W-1:0]   psum [gtig_pkg::NUM_BANDS];

  logic [gtig_pkg::RES_W-1:0]          r;
  logic [gtig_pkg::RES_W+1:0]          r3;
  logic [gtig_pkg::RES_W-1:0]          t;
  logic signed [gtig_pkg::DIM_W-1:0]   rs, qs, ts, rm2, rmt, tmq;
  logic signed [gtig_pkg::DIM_W-1:0]   w_dim [gtig_pkg::NUM_BANDS];
  logic signed [gtig_pkg::DIM_W-1:0]   h_dim [gtig_pkg::NUM_BANDS];
  logic [gtig_pkg::STEP_W-1:0]         mul_off, sum_off;
  logic [gtig_pkg::BAND_W-1:0]         mul_k, sum_k, sum_k1;
  logic [2*gtig_pkg::COORD_W-1:0]      prod;

  function automatic logic [gtig_pkg::COORD_W-1:0] dim_clip(
    input logic signed [gtig_pkg::DIM_W-1:0] d
  );
    logic [gtig_pkg::COORD_W-1:0] res;
    res = '0;
    if (d > $signed(gtig_pkg::DIM_W'(0))) begin
      res = gtig_pkg::COORD_W'(d);
    end
    return res;
  endfunction

  // Band extents from the resolution
  always_comb begin
    if (int'(resolution) > gtig_pkg::MAX_RESOLUTION) begin
      r = gtig_pkg::RES_W'(gtig_pkg::MAX_RESOLUTION);
    end else begin
      r = gtig_pkg::RES_W'(resolution);
    end
    r3  = {2'b00, r} + {1'b0, r, 1'b0};
    t   = r3[gtig_pkg::RES_W+1:2];
    rs  = $signed({2'b00, r});
    qs  = $signed({4'b0000, r[gtig_pkg::RES_W-1:2]});
    ts  = $signed({2'b00, t});
    rm2 = rs - $signed(gtig_pkg::DIM_W'(2));
    rmt = rs - ts;
    tmq = ts - qs;
    if (ring_mode) begin
      w_dim[0] = rm2; h_dim[0] = qs;
      w_dim[1] = qs;  h_dim[1] = tmq;
      w_dim[2] = rmt; h_dim[2] = tmq;
      w_dim[3] = rm2; h_dim[3] = rmt;
    end else begin
      for (int b = 0; b < gtig_pkg::NUM_BANDS; b++) begin
        w_dim[b] = rm2;
        h_dim[b] = rm2;
      end
    end
  end

  assign mul_off = step - gtig_pkg::STEP_MUL;
  assign sum_off = step - gtig_pkg::STEP_SUM;
  assign mul_k   = mul_off[gtig_pkg::BAND_W-1:0];
  assign sum_k   = sum_off[gtig_pkg::BAND_W-1:0];
  assign sum_k1  = sum_k + gtig_pkg::BAND_W'(1);
  assign prod    = wd[mul_k] * hd[mul_k];

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= gtig_pkg::RES_RESET;
      ring_mode  <= 1'b0;
      step       <= gtig_pkg::STEP_DIMS;
    end else if (cfg_valid) begin
      // restart the geometry sweep on any write
      case (cfg_index)
        gtig_pkg::REG_RESOLUTION: resolution <= cfg_data;
        gtig_pkg::REG_RING_MODE:  ring_mode  <= cfg_data[0];
        default: ;
      endcase
      step <= gtig_pkg::STEP_DIMS;
    end else if (step != gtig_pkg::STEP_IDLE) begin
      step <= step + gtig_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (step == gtig_pkg::STEP_DIMS) begin
      for (int b = 0; b < gtig_pkg::NUM_BANDS; b++) begin
        wd[b] <= dim_clip(w_dim[b]);
        hd[b] <= dim_clip(h_dim[b]);
      end
      psum[0] <= '0;
    end
    if (step >= gtig_pkg::STEP_MUL && step < gtig_pkg::STEP_SUM) begin
      vc[mul_k] <= gtig_pkg::IDX_W'(prod);
    end
    if (step >= gtig_pkg::STEP_SUM && step < gtig_pkg::STEP_RESETTLE) begin
      psum[sum_k1] <= psum[sum_k] + vc[sum_k];
    end
  end

  always_comb begin
    geom.ring = ring_mode;
    for (int b = 0; b < gtig_pkg::NUM_BANDS; b++) begin
      geom.band[b].wd = wd[b];
      geom.band[b].qc = (wd[b] > gtig_pkg::COORD_W'(1)) ? wd[b] - gtig_pkg::COORD_W'(1) : '0;
      geom.band[b].qr = (hd[b] > gtig_pkg::COORD_W'(1)) ? hd[b] - gtig_pkg::COORD_W'(1) : '0;
      geom.band[b].ok = (wd[b] > gtig_pkg::COORD_W'(1)) && (hd[b] > gtig_pkg::COORD_W'(1));
      geom.base[b]    = psum[b];
    end
  end

  assign busy     = (step != gtig_pkg::STEP_IDLE);
  assign resettle = (step == gtig_pkg::STEP_RESETTLE);

endmodule

`default_nettype wire

### design/gtig_settle.sv
// Moves the quad walk onto the next valid quad or marks the mesh done.
`default_nettype none

module gtig_settle (
  input  gtig_pkg::geom_t geom,
  input  gtig_pkg::walk_t cur,
  output gtig_pkg::walk_t nxt
);

  gtig_pkg::band_geom_t         g;
  logic                         in_range, wrap, stay, found;
  logic [gtig_pkg::BAND_W-1:0]  tgt;
  logic [gtig_pkg::COORD_W-1:0] col1, row1;
  logic [gtig_pkg::IDX_W-1:0]   rsi1, base1;

  always_comb begin
    g        = geom.band[cur.band];
    in_range = geom.ring || (cur.band == '0);
    wrap     = g.ok && (cur.col >= g.qc);
    col1     = wrap ? '0 : cur.col;
    row1     = wrap ? cur.row + gtig_pkg::COORD_W'(1) : cur.row;
    rsi1     = wrap ? cur.rsi + gtig_pkg::IDX_W'(g.wd) : cur.rsi;
    stay     = g.ok && (row1 < g.qr) && (col1 < g.qc);

    // first later band that holds quads
    found = 1'b0;
    tgt   = '0;
    for (int b = 0; b < gtig_pkg::NUM_BANDS; b++) begin
      if (!found && geom.ring && (gtig_pkg::BAND_W'(b) > cur.band) && geom.band[b].ok) begin
        found = 1'b1;
        tgt   = gtig_pkg::BAND_W'(b);
      end
    end
    base1 = cur.base + geom.base[tgt] - geom.base[cur.band];

    nxt = cur;
    if (!cur.fin) begin
      if (!in_range) begin
        nxt.fin = 1'b1;
      end else if (stay) begin
        nxt.col = col1;
        nxt.row = row1;
        nxt.rsi = rsi1;
      end else if (found) begin
        nxt.band = tgt;
        nxt.col  = '0;
        nxt.row  = '0;
        nxt.sh   = 1'b0;
        nxt.base = base1;
        nxt.rsi  = base1;
      end else begin
        nxt.fin = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/gtig_core.sv
// Walk state, triangle corner generation and result register.
`default_nettype none

module gtig_core (
  input  logic                          clk,
  input  logic                          rst,
  input  gtig_pkg::geom_t               geom,
  input  logic                          busy,
  input  logic                          resettle,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gtig_pkg::IDX_W-1:0]    out_corner_a,
  output logic [gtig_pkg::IDX_W-1:0]    out_corner_b,
  output logic [gtig_pkg::IDX_W-1:0]    out_corner_c,
  output logic                          out_last,
  output logic                          out_none_left
);

  gtig_pkg::walk_t state, held, start, pre, adv, settle_in, settle_out;
  gtig_pkg::band_geom_t        g;
  logic                        in_accept, first_found;
  logic [gtig_pkg::BAND_W-1:0] first_band;
  logic [gtig_pkg::IDX_W-1:0]  v, wv;

  assign in_ready  = !busy && (!out_valid || out_ready);
  assign in_accept = in_valid && in_ready;

  // Restart target: first band with quads
  always_comb begin
    first_found = 1'b0;
    first_band  = '0;
    for (int b = 0; b < gtig_pkg::NUM_BANDS; b++) begin
      if (!first_found && (geom.ring || b == 0) && geom.band[b].ok) begin
        first_found = 1'b1;
        first_band  = gtig_pkg::BAND_W'(b);
      end
    end
    start.band = first_band;
    start.col  = '0;
    start.row  = '0;
    start.rsi  = geom.base[first_band];
    start.base = geom.base[first_band];
    start.sh   = 1'b0;
    start.fin  = !first_found;
  end

  // A geometry change settles from the walk as the last request left it
  always_comb begin
    pre = in_restart ? start : state;
    g   = geom.band[pre.band];
    v   = pre.rsi + gtig_pkg::IDX_W'(pre.col);
    wv  = gtig_pkg::IDX_W'(g.wd);
    adv = pre;
    adv.sh = !pre.sh;
    if (pre.sh) begin
      adv.col = pre.col + gtig_pkg::COORD_W'(1);
    end
    settle_in = resettle ? held : adv;
  end

  gtig_settle u_settle (
    .geom (geom),
    .cur  (settle_in),
    .nxt  (settle_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gtig_pkg::WALK_RESET;
      held      <= gtig_pkg::WALK_RESET;
      out_valid <= 1'b0;
    end else begin
      if (resettle) begin
        state <= settle_out;
      end else if (in_accept) begin
        state <= pre.fin ? pre : settle_out;
        held  <= pre.fin ? pre : settle_out;
      end
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (pre.fin) begin
        out_corner_a  <= '0;
        out_corner_b  <= '0;
        out_corner_c  <= '0;
        out_last      <= 1'b0;
        out_none_left <= 1'b1;
      end else begin
        out_corner_a  <= v;
        out_corner_b  <= pre.sh ? v + wv + gtig_pkg::IDX_W'(1) : v + wv;
        out_corner_c  <= pre.sh ? v + gtig_pkg::IDX_W'(1) : v + wv + gtig_pkg::IDX_W'(1);
        out_last      <= settle_out.fin;
        out_none_left <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_stays_empty: assert property (@(posedge clk) disable iff (rst)
    in_accept && !in_restart && state.fin |=> out_valid && out_none_left)
    else $error("request after mesh end did not report none left");

  a_none_left_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_none_left |->
      out_corner_a == '0 && out_corner_b == '0 && out_corner_c == '0 && !out_last)
    else $error("none-left result carries indices");

  a_resettle_idle: assert property (@(posedge clk) disable iff (rst)
    resettle |-> !in_accept)
    else $error("request accepted during geometry resettle");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted request produced no result");
`endif

endmodule

`default_nettype wire

### design/grid_triangle_index_generator.sv
// Top level of the grid triangle index generator: one triangle per request.
// A result is registered and appears in the cycle after its request is accepted.
// One request per cycle while no sweep runs; the result register frees as it drains.
// A configuration write or reset starts a geometry sweep (dims, four
// vertex-count multiplies, three base sums, resettle) with s_axis_tready low.
// Reset: synchronous, R=64, full mode; requests report none left until restart.
`default_nettype none

module grid_triangle_index_generator (
  input  logic                           clk,
  input  logic                           rst,

  // Request channel
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [0] restart

  // Result channel
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [63:0]                    m_axis_tdata,   // corner_a, corner_b, corner_c
  output logic                           m_axis_tlast,   // last_triangle
  output logic [0:0]                     m_axis_tuser,   // none_left

  // Configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gtig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gtig_pkg::CFG_RES_W-1:0] cfg_data
);

  gtig_pkg::geom_t            geom;
  logic                       busy;
  logic                       resettle;
  logic [gtig_pkg::IDX_W-1:0] corner_a, corner_b, corner_c;
  logic                       none_left;

  // Writes are always taken; each one restarts the geometry sweep.
  assign cfg_ready = 1'b1;

  gtig_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .busy      (busy),
    .resettle  (resettle)
  );

  // Walk the quads and register each triangle
  gtig_core u_core (
    .clk           (clk),
    .rst           (rst),
    .geom          (geom),
    .busy          (busy),
    .resettle      (resettle),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_restart    (s_axis_tdata[0]),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_corner_a  (corner_a),
    .out_corner_b  (corner_b),
    .out_corner_c  (corner_c),
    .out_last      (m_axis_tlast),
    .out_none_left (none_left)
  );

  // Pack corners from the lowest bits, pad to whole bytes
  assign m_axis_tdata = {4'b0000, corner_c, corner_b, corner_a};
  assign m_axis_tuser = none_left;

endmodule

`default_nettype wire

### dv/tb_grid_triangle_index_generator.sv
// Self-checking testbench for the grid triangle index generator: request stream vs. predictor.
module tb_grid_triangle_index_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW = gtig_pkg::IDX_W;
  localparam int RW = gtig_pkg::CFG_RES_W;

  // Band numbering of ring mode, in walk order
  localparam int BAND_TOP    = 0;
  localparam int BAND_LEFT   = 1;
  localparam int BAND_RIGHT  = 2;
  localparam int BAND_BOTTOM = 3;

  localparam int TOTAL_REQUESTS  = 1450;
  localparam int RANDOM_REQUESTS = 1150;
  localparam int WALK_CAP        = 200;

  typedef struct packed {
    logic [IW-1:0] corner_a;
    logic [IW-1:0] corner_b;
    logic [IW-1:0] corner_c;
    logic          last_triangle;
    logic          none_left;
  } triangle_t;

  logic          clk;
  logic          rst = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [7:0]    s_axis_tdata = '0;       // [0] restart
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [63:0]   m_axis_tdata;            // [19:0] corner_a, [39:20] corner_b, [59:40] corner_c
  logic          m_axis_tlast;            // last_triangle
  logic [0:0]    m_axis_tuser;            // [0] none_left
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [gtig_pkg::CFG_IDX_W-1:0] cfg_index = gtig_pkg::REG_RESOLUTION;
  logic [RW-1:0] cfg_data = '0;

  grid_triangle_index_generator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: shadow registers plus the walk counters of the block.
  // ---------------------------------------------------------------------------
  logic [RW-1:0] res_reg  = RW'(64);
  logic          ring_reg = 1'b0;

  logic [1:0]    walk_band = '0;
  logic [9:0]    walk_col  = '0;
  logic [9:0]    walk_row  = '0;
  logic [IW-1:0] walk_rsi  = '0;   // index of the first vertex of the current row
  logic [IW-1:0] walk_base = '0;   // index of the first vertex of the current band
  logic          walk_sh   = 1'b0; // second triangle of the quad is next
  logic          walk_fin  = 1'b1; // nothing left until a restart

  triangle_t expected_triangles[$];
  int        errors        = 0;
  int        requests_sent = 0;
  int        stall_cycles  = 0;
  bit        sender_calm   = 1'b0;
  bit        receiver_calm = 1'b0;

  // Width, vertex count, quad columns and quad rows of band b under the current registers.
  function automatic void band_shape(input int b, output int w, output int vc,
                                     output int qc, output int qr);
    int r, q, t, x0, x1, y0, y1, h;
    r = (int'(res_reg) > gtig_pkg::MAX_RESOLUTION) ? gtig_pkg::MAX_RESOLUTION : int'(res_reg);
    q = r / 4;
    t = (3 * r) / 4;
    if (!ring_reg) begin
      x0 = 0; x1 = r - 2; y0 = 0; y1 = r - 2;
    end else begin
      case (b)
        BAND_TOP: begin
          x0 = 0; x1 = r - 2; y0 = 0; y1 = q;
        end
        BAND_LEFT: begin
          x0 = 0; x1 = q; y0 = q - 1; y1 = t - 1;
        end
        BAND_RIGHT: begin
          x0 = t - 2; x1 = r - 2; y0 = q - 1; y1 = t - 1;
        end
        default: begin
          x0 = 0; x1 = r - 2; y0 = t - 2; y1 = r - 2;
        end
      endcase
    end
    w  = x1 - x0;
    h  = y1 - y0;
    vc = (w > 0 && h > 0) ? w * h : 0;
    qc = (w > 1) ? w - 1 : 0;
    qr = (h > 1) ? h - 1 : 0;
  endfunction

  // Move the counters onto the next quad that exists, or mark the mesh done.
  function automatic void seek_quad();
    int nbands, w, vc, qc, qr;
    nbands = ring_reg ? gtig_pkg::NUM_BANDS : 1;
    while (1) begin
      if (int'(walk_band) >= nbands) begin
        walk_fin = 1'b1;
        return;
      end
      band_shape(int'(walk_band), w, vc, qc, qr);
      // Column past the band's quads: wrap to the next row.
      if (qc > 0 && qr > 0 && int'(walk_col) >= qc) begin
        walk_col = '0;
        walk_row = walk_row + 1'b1;
        walk_rsi = walk_rsi + IW'(w);
      end
      if (qc > 0 && qr > 0 && int'(walk_row) < qr && int'(walk_col) < qc) return;
      if (int'(walk_band) + 1 >= nbands) begin
        walk_fin = 1'b1;
        return;
      end
      // Band exhausted or empty: step past its vertices into the next band.
      walk_base = walk_base + IW'(vc);
      walk_band = walk_band + 1'b1;
      walk_row  = '0;
      walk_col  = '0;
      walk_sh   = 1'b0;
      walk_rsi  = walk_base;
    end
  endfunction

  // Expected triangle for one accepted request; advances the shadow counters.
  function automatic triangle_t next_triangle(input logic restart);
    triangle_t     result;
    int            w, vc, qc, qr;
    logic [IW-1:0] v, uw;
    result = '0;
    if (restart) begin
      walk_band = '0;
      walk_col  = '0;
      walk_row  = '0;
      walk_rsi  = '0;
      walk_base = '0;
      walk_sh   = 1'b0;
      walk_fin  = 1'b0;
    end
    if (!walk_fin) seek_quad();
    if (walk_fin) begin
      result.none_left = 1'b1;
      return result;
    end
    band_shape(int'(walk_band), w, vc, qc, qr);
    uw = IW'(w);
    v  = walk_rsi + IW'(walk_col);
    result.corner_a = v;
    if (!walk_sh) begin
      result.corner_b = v + uw;
      result.corner_c = v + uw + 1'b1;
      walk_sh = 1'b1;
    end else begin
      result.corner_b = v + uw + 1'b1;
      result.corner_c = v + 1'b1;
      walk_sh  = 1'b0;
      walk_col = walk_col + 1'b1;
    end
    seek_quad();
    result.last_triangle = walk_fin;
    return result;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 100) $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Compare every accepted result with the oldest expected triangle.
  always @(posedge clk) begin : result_checker
    triangle_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.corner_a      = m_axis_tdata[IW-1:0];
      got.corner_b      = m_axis_tdata[2*IW-1:IW];
      got.corner_c      = m_axis_tdata[3*IW-1:2*IW];
      got.last_triangle = m_axis_tlast;
      got.none_left     = m_axis_tuser[0];
      if (expected_triangles.size() == 0) begin
        report_mismatch("result with no request pending", got.corner_a, 0);
      end else begin
        want = expected_triangles.pop_front();
        if (got.corner_a !== want.corner_a)
          report_mismatch("corner_a", got.corner_a, want.corner_a);
        if (got.corner_b !== want.corner_b)
          report_mismatch("corner_b", got.corner_b, want.corner_b);
        if (got.corner_c !== want.corner_c)
          report_mismatch("corner_c", got.corner_c, want.corner_c);
        if (got.last_triangle !== want.last_triangle)
          report_mismatch("last_triangle", got.last_triangle, want.last_triangle);
        if (got.none_left !== want.none_left)
          report_mismatch("none_left", got.none_left, want.none_left);
      end
    end
  end

  // Result side: random stall bursts, or one long hold-off when a test asks for it.
  initial begin : result_receiver
    int hold;
    forever begin
      @(negedge clk);
      if (stall_cycles > 0) begin
        hold = stall_cycles;
        stall_cycles = 0;
        m_axis_tready <= 1'b0;
        repeat (hold) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else if (!receiver_calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. Every task below starts and ends at a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one request, hold it until accepted, and record its expected triangle.
  task automatic send_request(input logic restart);
    if (!sender_calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, restart};
    do @(posedge clk); while (!s_axis_tready);
    expected_triangles.push_back(next_triangle(restart));
    requests_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every pending result has drained.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (expected_triangles.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write both registers while the block is idle; counters are left untouched.
  task automatic configure(input logic [RW-1:0] res, input logic ring);
    wait_for_results();
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      if (i == 0) begin
        cfg_index <= gtig_pkg::REG_RESOLUTION;
        cfg_data  <= res;
      end else begin
        // Upper data bits are don't-care for the mode register: randomize them.
        cfg_index <= gtig_pkg::REG_RING_MODE;
        cfg_data  <= {(RW-1)'($urandom), ring};
      end
      do @(posedge clk); while (!cfg_ready);
      if (cfg_index == gtig_pkg::REG_RESOLUTION) res_reg = cfg_data;
      else ring_reg = cfg_data[0];
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Keep asking for the next triangle until the mesh ends or the cap is hit;
  // sprinkle in the odd restart and a few requests past the end.
  task automatic continue_mesh(input int limit);
    int n;
    n = 0;
    while (!walk_fin && n < limit) begin
      send_request($urandom_range(0, 39) == 0);
      n++;
    end
    if (walk_fin) repeat ($urandom_range(0, 2)) send_request(1'b0);
  endtask

  task automatic walk_mesh(input int limit);
    send_request(1'b1);
    continue_mesh(limit - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset nothing is armed: every request reports none left.
  task automatic test_requests_before_restart();
    send_request(1'b0);
    send_request(1'b0);
  endtask

  // Smallest full grid: one quad, two triangles, then none left; restart mid-mesh too.
  task automatic test_tiny_full_mesh();
    configure(RW'(4), 1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);
  endtask

  // Resolutions too small for any quad, in both modes: none left at once.
  task automatic test_degenerate_resolutions();
    configure(RW'(0), 1'b0);
    send_request(1'b1);
    send_request(1'b0);
    configure(RW'(3), 1'b0);
    send_request(1'b1);
    configure(RW'(4), 1'b1);
    send_request(1'b1);
    send_request(1'b0);
    configure(RW'(2), 1'b1);
    send_request(1'b1);
  endtask

  // Oversized resolution clamps to the maximum; largest legal ring mesh.
  task automatic test_largest_resolutions();
    configure({RW{1'b1}}, 1'b0);
    walk_mesh(4);
    configure(RW'(gtig_pkg::MAX_RESOLUTION), 1'b1);
    walk_mesh(3);
  endtask

  // Random geometries, mostly small so meshes run to completion; some phases
  // change the geometry halfway through a mesh without a restart.
  task automatic test_random_meshes(input int target);
    logic [RW-1:0] res;
    int            pick;
    while (requests_sent < target) begin
      sender_calm   = ($urandom_range(0, 3) == 0);
      receiver_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick == 0) res = RW'($urandom_range(0, 3));
      else if (pick == 1) res = RW'($urandom_range(gtig_pkg::MAX_RESOLUTION, 2047));
      else if (pick == 2) res = RW'($urandom);
      else res = RW'($urandom_range(4, 12));
      configure(res, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 7) == 0) begin
        walk_mesh($urandom_range(1, 30));
        configure(RW'($urandom_range(4, 12)), 1'($urandom_range(0, 1)));
        continue_mesh(WALK_CAP);
      end else begin
        walk_mesh(WALK_CAP);
      end
    end
  endtask

  // Hold the result side off for a long stretch while requests keep coming,
  // so the block fills up and stalls its input.
  task automatic test_output_stall();
    sender_calm   = 1'b1;
    receiver_calm = 1'b1;
    configure(RW'(10), 1'b0);
    stall_cycles = 250;
    walk_mesh(30);
    wait_for_results();
  endtask

  // Stop sending mid-mesh until everything has drained, then carry on.
  task automatic test_pause_mid_mesh();
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    configure(RW'(8), 1'b1);
    walk_mesh(12);
    wait_for_results();
    continue_mesh(WALK_CAP);
  endtask

  // Closing stretch at full rate on both sides; the last mesh is cut at the target.
  task automatic test_steady_stream(input int target);
    sender_calm   = 1'b1;
    receiver_calm = 1'b1;
    while (requests_sent < target) begin
      configure(RW'($urandom_range(4, 12)), 1'($urandom_range(0, 1)));
      walk_mesh((target - requests_sent < WALK_CAP) ? target - requests_sent : WALK_CAP);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_requests_before_restart();
    test_tiny_full_mesh();
    test_degenerate_resolutions();
    test_largest_resolutions();
    test_random_meshes(RANDOM_REQUESTS / 2);
    test_output_stall();
    test_pause_mid_mesh();
    test_random_meshes(RANDOM_REQUESTS);
    test_steady_stream(TOTAL_REQUESTS);

    // Let the last results drain, then allow a few cycles for anything stray.
    wait_for_results();
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
